[design/modbus_response_crc_check_macros.svh]
// Assertion macros shared by the Modbus response CRC checker.
`ifndef MODBUS_RESPONSE_CRC_CHECK_MACROS_SVH
`define MODBUS_RESPONSE_CRC_CHECK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MRCC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mrcc_pkg.sv]
// Types, constants and the CRC byte update for the Modbus response CRC checker.
package mrcc_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int POS_W = 3;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CRC_BYTES = POS_W'(5);
  localparam logic [POS_W-1:0] VALUE_HI_POS = POS_W'(3);
  localparam logic [POS_W-1:0] VALUE_LO_POS = POS_W'(4);
  localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(5);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Reciprocal of ten scaled by 2^19; exact for every 16-bit reading.
  localparam logic [15:0] RECIP_TEN = 16'hCCCD;
  localparam int RECIP_SHIFT = 19;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic        frame_ok;
    logic [12:0] whole_part;
    logic [3:0]  tenth_digit;
  } out_word_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] reading;
  } check_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] data_in);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

[design/mrcc_frame.sv]
// Frame position tracking, running CRC-16, capture of the reading bytes and received CRC, and the CRC compare.
module mrcc_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  mrcc_pkg::in_word_t word,
  output logic              done,
  output mrcc_pkg::check_t  check
);

  logic [mrcc_pkg::POS_W-1:0] pos;
  logic [mrcc_pkg::POS_W-1:0] pos_next;
  logic [mrcc_pkg::POS_W-1:0] pos_eff;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] crc_base;
  logic [7:0]  value_high;
  logic [7:0]  value_low;
  logic [7:0]  crc_low_received;
  logic        restart;
  logic        last;

  always_comb begin
    restart  = word.frame_start || (pos > mrcc_pkg::LAST_POS);
    pos_eff  = restart ? '0 : pos;
    crc_base = restart ? mrcc_pkg::CRC_INIT : crc;
    last     = (pos_eff == mrcc_pkg::LAST_POS);
    if (last) begin
      pos_next = '0;
      crc_next = mrcc_pkg::CRC_INIT;
    end else begin
      pos_next = pos_eff + mrcc_pkg::POS_W'(1);
      crc_next = (pos_eff < mrcc_pkg::CRC_BYTES) ?
                 mrcc_pkg::crc_update(crc_base, word.rx_byte) : crc_base;
    end
  end

  assign done          = take && last;
  assign check.ok      = (crc_low_received == crc_base[7:0]) &&
                         (word.rx_byte == crc_base[15:8]);
  assign check.reading = {value_high, value_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      crc              <= mrcc_pkg::CRC_INIT;
      value_high       <= '0;
      value_low        <= '0;
      crc_low_received <= '0;
    end else if (take) begin
      pos <= pos_next;
      crc <= crc_next;
      if (pos_eff == mrcc_pkg::VALUE_HI_POS) begin
        value_high <= word.rx_byte;
      end
      if (pos_eff == mrcc_pkg::VALUE_LO_POS) begin
        value_low <= word.rx_byte;
      end
      if (pos_eff == mrcc_pkg::CRC_LO_POS) begin
        crc_low_received <= word.rx_byte;
      end
    end
  end

endmodule

[design/mrcc_div10.sv]
// Splits a checked reading into its tenths digit and whole part; both are zero when the check failed.
module mrcc_div10 (
  input  mrcc_pkg::check_t   check,
  output mrcc_pkg::out_word_t result
);

  logic [31:0] product;
  logic [12:0] quotient;
  logic [15:0] times_ten;
  logic [15:0] remainder;

  always_comb begin
    product   = 32'(check.reading) * 32'(mrcc_pkg::RECIP_TEN);
    quotient  = product[mrcc_pkg::RECIP_SHIFT +: 13];
    times_ten = {quotient, 3'b000} + {2'b00, quotient, 1'b0};
    remainder = check.reading - times_ten;
    result.frame_ok    = check.ok;
    result.whole_part  = check.ok ? quotient : '0;
    result.tenth_digit = check.ok ? remainder[3:0] : '0;
  end

endmodule

[design/modbus_response_crc_check.sv]
// Top level of the Modbus RTU read-response CRC checker.
// Usage: response bytes enter one word per cycle on data_valid/data_ready,
// with frame_start marking the first byte of a seven-byte frame. Bytes 0..4
// feed a reflected CRC-16 (init 0xFFFF, polynomial 0xA001); bytes 3 and 4
// form the big-endian reading; bytes 5 and 6 are the received CRC.
// On byte 6 one result word leaves on result_valid/result_ready: the pass
// flag, the reading divided by ten and the tenths digit, both zero on fail.
// Bytes 0..5 produce no result word.
// Once its last byte is accepted, a result is registered in the check stage after
// the CRC compare and then in the output stage after the divide by ten.
// Throughput: one byte per cycle while data_ready is high; the CRC byte update is combinational.
// Reset clears the frame position, restarts the CRC and empties both stages.
// When result_ready is low the result word holds; the middle stage still
// fills, and data_ready falls only once both stages are occupied.
module modbus_response_crc_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_ready,
  input  mrcc_pkg::in_word_t  data,
  output logic                result_valid,
  input  logic                result_ready,
  output mrcc_pkg::out_word_t result
);

  logic                check_valid;
  mrcc_pkg::check_t    check_word;
  logic                frame_done;
  mrcc_pkg::check_t    frame_check;
  mrcc_pkg::out_word_t split_word;
  logic                out_free;
  logic                check_free;
  logic                take;
  logic                fail_out;
  logic                fields_zero;
  logic                digit_ok;
  logic                both_full;
  logic                held;

  assign out_free   = !result_valid || result_ready;
  assign check_free = !check_valid || out_free;
  assign data_ready = check_free;
  assign take       = data_valid && data_ready;

  mrcc_frame u_frame (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .word  (data),
    .done  (frame_done),
    .check (frame_check)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      check_valid <= 1'b0;
    end else if (check_free) begin
      check_valid <= frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (check_free && frame_done) begin
      check_word <= frame_check;
    end
  end

  mrcc_div10 u_div10 (
    .check  (check_word),
    .result (split_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= check_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && check_valid) begin
      result <= split_word;
    end
  end

  assign fail_out    = result_valid && !result.frame_ok;
  assign fields_zero = (result.whole_part == '0) && (result.tenth_digit == '0);
  assign digit_ok    = result.tenth_digit < 4'd10;
  assign both_full   = check_valid && result_valid && !result_ready;
  assign held        = check_valid && !out_free;

`include "modbus_response_crc_check_macros.svh"

  `MRCC_ASSERT_IMP(fail_zeroes_fields, clk, rst, fail_out, fields_zero, "failed frame has a reading")
  `MRCC_ASSERT_IMP(digit_in_range, clk, rst, result_valid, digit_ok, "tenths digit out of range")
  `MRCC_ASSERT_IMP(stall_only_when_full, clk, rst, !data_ready, both_full, "stall with a stage free")
  `MRCC_ASSERT_NEXT(check_stage_holds, clk, rst, held, $stable({check_valid, check_word}), "check word lost")

endmodule

[tb/modbus_response_crc_check_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Modbus RTU read-response CRC checker.
module modbus_response_crc_check_test;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CRC_LO,
    FRAME_BAD_CRC_HI,
    FRAME_BAD_DATA
  } frame_kind_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                data_valid = 1'b0;
  logic                data_ready;
  mrcc_pkg::in_word_t  data = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  mrcc_pkg::out_word_t result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;

  always #5 clk = ~clk;

  modbus_response_crc_check uut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data         (data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ mrcc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  class crc_frame_scoreboard;
    logic [15:0]                crc;
    logic [mrcc_pkg::POS_W-1:0] pos;
    logic [7:0]                 value_hi;
    logic [7:0]                 value_lo;
    logic [7:0]                 crc_lo_rx;
    mrcc_pkg::out_word_t        expected_q[$];
    int                         errors;

    function new();
      crc = mrcc_pkg::CRC_INIT;
      pos = '0;
      value_hi = '0;
      value_lo = '0;
      crc_lo_rx = '0;
      errors = 0;
    endfunction

    function bit at_boundary();
      return pos == '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(mrcc_pkg::in_word_t w);
      mrcc_pkg::out_word_t want;
      logic [15:0]         reading;
      if (w.frame_start || pos > mrcc_pkg::LAST_POS) begin
        pos = '0;
        crc = mrcc_pkg::CRC_INIT;
      end
      if (pos < mrcc_pkg::CRC_BYTES) begin
        crc = crc16_step(crc, w.rx_byte);
      end
      if (pos == mrcc_pkg::VALUE_HI_POS) begin
        value_hi = w.rx_byte;
      end
      if (pos == mrcc_pkg::VALUE_LO_POS) begin
        value_lo = w.rx_byte;
      end
      if (pos == mrcc_pkg::CRC_LO_POS) begin
        crc_lo_rx = w.rx_byte;
      end
      if (pos == mrcc_pkg::LAST_POS) begin
        reading = {value_hi, value_lo};
        want = '0;
        if (crc_lo_rx == crc[7:0] && w.rx_byte == crc[15:8]) begin
          want.frame_ok = 1'b1;
          want.whole_part = 13'(reading / 16'd10);
          want.tenth_digit = 4'(reading % 16'd10);
        end
        expected_q.push_back(want);
        pos = '0;
        crc = mrcc_pkg::CRC_INIT;
      end else begin
        pos = pos + 1'b1;
      end
    endfunction

    function void check_result(mrcc_pkg::out_word_t got);
      mrcc_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        $error("result word %h arrived with no frame pending", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.frame_ok !== want.frame_ok) begin
        $error("frame_ok: expected %0d, actual %0d", want.frame_ok, got.frame_ok);
        errors++;
      end
      if (got.whole_part !== want.whole_part) begin
        $error("whole_part: expected %0d, actual %0d", want.whole_part, got.whole_part);
        errors++;
      end
      if (got.tenth_digit !== want.tenth_digit) begin
        $error("tenth_digit: expected %0d, actual %0d", want.tenth_digit, got.tenth_digit);
        errors++;
      end
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0) begin
        $error("%0d expected result words never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

  crc_frame_scoreboard sb;

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_result(result);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    if ($urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    data_valid <= 1'b1;
    data <= '{rx_byte: b, frame_start: s};
    do @(posedge clk); while (!data_ready);
    sb.note_byte('{rx_byte: b, frame_start: s});
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] reading, input frame_kind_t kind, input logic s);
    logic [7:0]  fb [7];
    logic [15:0] c;
    int          idx;
    fb[0] = 8'($urandom);
    fb[1] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h03;
    fb[2] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h02;
    fb[3] = reading[15:8];
    fb[4] = reading[7:0];
    c = mrcc_pkg::CRC_INIT;
    for (int i = 0; i < 5; i++) begin
      c = crc16_step(c, fb[i]);
    end
    fb[5] = c[7:0];
    fb[6] = c[15:8];
    case (kind)
      FRAME_BAD_CRC_LO: begin
        fb[5] = fb[5] ^ 8'(1 << $urandom_range(7));
      end
      FRAME_BAD_CRC_HI: begin
        fb[6] = fb[6] ^ 8'(1 << $urandom_range(7));
      end
      FRAME_BAD_DATA: begin
        idx = $urandom_range(4);
        fb[idx] = fb[idx] ^ 8'(1 << $urandom_range(7));
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 7; i++) begin
      send_byte(fb[i], (i == 0) ? s : 1'b0);
    end
  endtask

  task automatic send_partial(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom), (i == 0));
    end
  endtask

  function automatic logic [15:0] pick_reading();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(99));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n_bytes);
    int          target;
    int          r;
    logic        s;
    frame_kind_t kind;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      s = sb.at_boundary() ? 1'($urandom_range(1)) : 1'b1;
      if (r < 75) begin
        send_frame(pick_reading(), FRAME_GOOD, s);
      end else if (r < 87) begin
        case ($urandom_range(2))
          0: kind = FRAME_BAD_CRC_LO;
          1: kind = FRAME_BAD_CRC_HI;
          default: kind = FRAME_BAD_DATA;
        endcase
        send_frame(pick_reading(), kind, s);
      end else if (r < 95) begin
        send_partial($urandom_range(6, 1));
      end else begin
        repeat ($urandom_range(10, 1)) begin
          send_byte(8'($urandom), ($urandom_range(3) == 0));
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 60;
    send_frame(16'hFFFF, FRAME_GOOD, 1'b1);
    send_frame(16'h0000, FRAME_GOOD, 1'b0);
    send_partial(3);
    send_frame(16'd1234, FRAME_BAD_CRC_LO, 1'b1);
    run_random(600);

    send_idle_pct = 60;
    recv_idle_pct = 30;
    run_random(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(600);

    data_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("modbus_response_crc_check regression: pass");
    end else begin
      $display("modbus_response_crc_check regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("modbus_response_crc_check regression: fail");
    $finish;
  end

endmodule
